// ----- sv/whp_pkg.sv -----
// whp_pkg: shared types and constants of the wav header parser
// used by whp_divider, whp_parser and wav_header_parser_top; no dependencies
package whp_pkg;

    // clock and the sample interval dividend
    localparam int unsigned CLOCK_HZ   = 16000000;
    localparam int unsigned DIVIDEND   = CLOCK_HZ / 8;
    localparam int unsigned DIV_W      = $clog2(DIVIDEND + 1);
    localparam int unsigned DIV_CNT_W  = $clog2(DIV_W);
    localparam logic [DIV_W-1:0] DIVIDEND_V = DIV_W'(DIVIDEND);

    // rate limits, the divisor fits in RATE_W bits once checked
    localparam int unsigned RATE_W     = 16;
    localparam logic [31:0] RATE_MIN   = 32'd8000;
    localparam logic [31:0] RATE_MAX   = 32'd48000;

    // chunk limits
    localparam logic [31:0] FMT_LEN_MIN  = 32'd16;
    localparam logic [31:0] FMT_LEN_MAX  = 32'd100;
    localparam logic [31:0] DATA_LEN_MIN = 32'd1024;

    // tags, first character in the lowest byte
    localparam logic [31:0] TAG_WAVE = 32'h45564157;
    localparam logic [31:0] TAG_FMT  = 32'h20746d66;
    localparam logic [31:0] TAG_DATA = 32'h61746164;
    localparam logic [31:0] TAG_LIST = 32'h5453494c;
    localparam logic [31:0] TAG_DISP = 32'h50534944;
    localparam logic [31:0] TAG_FACT = 32'h74636166;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_IO_ERR  = 2'd2;
    localparam logic [1:0] ST_RATE    = 2'd3;

    // one result item
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] data_bytes;
        logic [31:0] data_offset;
        logic [1:0]  channels;
        logic [4:0]  sample_bits;
        logic [7:0]  sample_interval;
    } whp_result_t;

    // divider request and response
    typedef struct packed {
        logic              start;
        logic [RATE_W-1:0] divisor;
    } whp_div_req_t;

    typedef struct packed {
        logic       busy;
        logic       done;
        logic [7:0] quotient;
    } whp_div_rsp_t;

endpackage

// ----- sv/wav_header_parser_top.sv -----
// wav_header_parser_top: one byte item per cycle when not stalled, one verdict item per file
// the verdict is registered and on the output in the cycle after the deciding byte item
// one byte item per cycle while the output register is free or read; the last byte of a good
//   fmt chunk holds the input while the divider runs
// reset: aresetn synchronous active low, parser idle until a first_byte item
// depends on whp_pkg, whp_parser, whp_divider
module wav_header_parser_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic [2:0]  s_tuser,   // first_byte, end_of_file, io_error
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // data_bytes, data_offset, channels, sample_bits,
                                   // sample_interval, zero pad
    output logic [1:0]  m_tuser    // status
);

    logic                  item_valid;
    logic                  busy;
    logic                  res_valid;
    whp_pkg::whp_result_t  res;
    whp_pkg::whp_div_req_t div_req;
    whp_pkg::whp_div_rsp_t div_rsp;
    logic                  m_valid_reg, m_valid_next;
    whp_pkg::whp_result_t  m_res_reg, m_res_next;

    assign s_tready   = !busy && (!m_valid_reg || m_tready);
    assign item_valid = s_tvalid && s_tready;

    whp_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_valid  (item_valid),
        .data_byte   (s_tdata),
        .first_byte  (s_tuser[0]),
        .end_of_file (s_tuser[1]),
        .io_error    (s_tuser[2]),
        .busy        (busy),
        .div_req     (div_req),
        .div_rsp     (div_rsp),
        .res_valid   (res_valid),
        .res         (res)
    );

    whp_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {1'b0, m_res_reg.sample_interval, m_res_reg.sample_bits,
                       m_res_reg.channels, m_res_reg.data_offset, m_res_reg.data_bytes};

`ifndef SYNTH
    // no item taken while the divider runs
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.busy |-> !s_tready)
        else $error("item accepted during division");

    // a verdict never overwrites a waiting item
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (!m_valid_reg || m_tready))
        else $error("verdict overwrote pending item");

    // a playable verdict carries a channel count
    a_ok_has_channels: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == whp_pkg::ST_OK) |-> (m_tdata[65:64] != 2'd0))
        else $error("playable verdict without channels");

    // division starts only from an accepted byte item
    a_div_from_item: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> item_valid)
        else $error("division started without item");
`endif

endmodule

// ----- sv/whp_divider.sv -----
// whp_divider: restoring divider, one quotient bit per cycle
// computes the low byte of DIVIDEND / divisor; uses whp_pkg
module whp_divider (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  whp_pkg::whp_div_req_t req,
    output whp_pkg::whp_div_rsp_t rsp
);

    logic                           busy_reg, busy_next;
    logic [whp_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [whp_pkg::RATE_W-1:0]     rem_reg, rem_next;
    logic [whp_pkg::RATE_W-1:0]     div_reg, div_next;
    logic [7:0]                     quo_reg, quo_next;
    logic [whp_pkg::RATE_W:0]       rem_sh;
    logic [whp_pkg::RATE_W:0]       rem_sub;
    logic                           q_bit;

    // one subtract and compare step
    always_comb begin
        rem_sh  = {rem_reg, whp_pkg::DIVIDEND_V[cnt_reg]};
        rem_sub = rem_sh - {1'b0, div_reg};
        q_bit   = (rem_sh >= {1'b0, div_reg});
    end

    // sequencing
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        quo_next  = quo_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = whp_pkg::DIV_CNT_W'(whp_pkg::DIV_W - 1);
            rem_next  = '0;
            div_next  = req.divisor;
            quo_next  = '0;
        end else if (busy_reg) begin
            rem_next = q_bit ? rem_sub[whp_pkg::RATE_W-1:0] : rem_sh[whp_pkg::RATE_W-1:0];
            quo_next = {quo_reg[6:0], q_bit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        div_reg <= div_next;
        quo_reg <= quo_next;
    end

    // last step completes this cycle
    assign rsp.busy     = busy_reg;
    assign rsp.done     = busy_reg && (cnt_reg == '0);
    assign rsp.quotient = {quo_reg[6:0], q_bit};

endmodule

// ----- sv/whp_parser.sv -----
// whp_parser: byte sequencer of the riff wave header and the fmt checks
// drives whp_divider for the sample interval; uses whp_pkg
module whp_parser (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  item_valid,
    input  logic [7:0]            data_byte,
    input  logic                  first_byte,
    input  logic                  end_of_file,
    input  logic                  io_error,
    output logic                  busy,
    output whp_pkg::whp_div_req_t div_req,
    input  whp_pkg::whp_div_rsp_t div_rsp,
    output logic                  res_valid,
    output whp_pkg::whp_result_t  res
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_HEAD = 3'd1;
    localparam logic [2:0] PH_CHDR = 3'd2;
    localparam logic [2:0] PH_FMT  = 3'd3;
    localparam logic [2:0] PH_SKIP = 3'd4;
    localparam logic [2:0] PH_DIV  = 3'd5;

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  count_reg, count_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] skip_reg, skip_next;
    logic [31:0] offset_reg, offset_next;
    logic [2:0]  align_reg, align_next;
    logic [7:0]  interval_reg, interval_next;
    logic [7:0]  fmt_bytes [16];

    logic        fmt_we;
    logic [3:0]  fmt_idx;
    logic        vflag;
    logic [1:0]  v_status;
    logic [31:0] v_len;
    logic [31:0] v_off;
    logic [2:0]  ph;
    logic [31:0] lenp;
    logic [2:0]  mask;
    logic [31:0] rate32;
    logic [2:0]  al;

    // next state of the header walk
    always_comb begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        tag_next      = tag_reg;
        len_next      = len_reg;
        skip_next     = skip_reg;
        offset_next   = offset_reg;
        align_next    = align_reg;
        interval_next = interval_reg;
        fmt_we        = 1'b0;
        fmt_idx       = count_reg[3:0];
        vflag         = 1'b0;
        v_status      = whp_pkg::ST_INVALID;
        v_len         = '0;
        v_off         = '0;
        ph            = phase_reg;
        lenp          = '0;
        mask          = '0;
        rate32        = '0;
        al            = '0;
        div_req       = '0;

        if (phase_reg == PH_DIV) begin
            // divider finishing: interval is quotient minus one
            if (div_rsp.done) begin
                interval_next = div_rsp.quotient - 8'd1;
                phase_next    = PH_CHDR;
                count_next    = '0;
            end
        end else if (item_valid) begin
            if (first_byte) begin
                count_next    = '0;
                tag_next      = '0;
                len_next      = '0;
                skip_next     = '0;
                offset_next   = '0;
                align_next    = '0;
                interval_next = '0;
                ph            = PH_HEAD;
            end
            phase_next = ph;
            if (ph != PH_IDLE) begin
                if (io_error) begin
                    vflag    = 1'b1;
                    v_status = (ph == PH_HEAD) ? whp_pkg::ST_IO_ERR : whp_pkg::ST_INVALID;
                end else if (end_of_file) begin
                    vflag = 1'b1;
                end else begin
                    offset_next = offset_next + 32'd1;
                    unique case (ph)
                        PH_HEAD: begin
                            if (count_next >= 8'd8) begin
                                tag_next = {data_byte, tag_next[31:8]};
                            end
                            count_next = count_next + 8'd1;
                            if (count_next >= 8'd12) begin
                                if (tag_next != whp_pkg::TAG_WAVE) begin
                                    vflag = 1'b1;
                                end else begin
                                    phase_next = PH_CHDR;
                                    count_next = '0;
                                end
                            end
                        end
                        PH_CHDR: begin
                            if (count_next < 8'd4) begin
                                tag_next = {data_byte, tag_next[31:8]};
                            end else begin
                                len_next = {data_byte, len_next[31:8]};
                            end
                            count_next = count_next + 8'd1;
                            if (count_next >= 8'd8) begin
                                lenp = len_next + {31'd0, len_next[0]};
                                mask = align_next - 3'd1;
                                if (tag_next == whp_pkg::TAG_FMT) begin
                                    if (lenp > whp_pkg::FMT_LEN_MAX ||
                                        lenp < whp_pkg::FMT_LEN_MIN) begin
                                        vflag = 1'b1;
                                    end else begin
                                        len_next   = lenp;
                                        count_next = '0;
                                        phase_next = PH_FMT;
                                    end
                                end else if (tag_next == whp_pkg::TAG_DATA) begin
                                    vflag = 1'b1;
                                    if (align_next != '0 &&
                                        len_next >= whp_pkg::DATA_LEN_MIN &&
                                        (len_next[2:0] & mask) == '0 &&
                                        (offset_next[2:0] & mask) == '0) begin
                                        v_status = whp_pkg::ST_OK;
                                        v_len    = len_next;
                                        v_off    = offset_next;
                                    end
                                end else if (tag_next == whp_pkg::TAG_DISP ||
                                             tag_next == whp_pkg::TAG_LIST ||
                                             tag_next == whp_pkg::TAG_FACT) begin
                                    if (lenp == '0) begin
                                        phase_next = PH_CHDR;
                                        count_next = '0;
                                    end else begin
                                        skip_next  = lenp;
                                        phase_next = PH_SKIP;
                                    end
                                end else begin
                                    vflag = 1'b1;
                                end
                            end
                        end
                        PH_FMT: begin
                            if (count_next < 8'd16) begin
                                fmt_we  = 1'b1;
                                fmt_idx = count_next[3:0];
                            end
                            count_next = count_next + 8'd1;
                            if ({24'd0, count_next} >= len_next) begin
                                // checks in order coding, channels, bits, rate
                                rate32 = {fmt_bytes[7], fmt_bytes[6], fmt_bytes[5], fmt_bytes[4]};
                                if (fmt_bytes[0] != 8'd1) begin
                                    vflag = 1'b1;
                                end else if (fmt_bytes[2] != 8'd1 && fmt_bytes[2] != 8'd2) begin
                                    vflag = 1'b1;
                                end else if (fmt_bytes[14] != 8'd8 && fmt_bytes[14] != 8'd16) begin
                                    align_next = '0;
                                    vflag      = 1'b1;
                                end else begin
                                    al = (fmt_bytes[14] == 8'd16) ?
                                         {fmt_bytes[2][1:0], 1'b0} : {1'b0, fmt_bytes[2][1:0]};
                                    align_next = al;
                                    if (rate32 < whp_pkg::RATE_MIN || rate32 > whp_pkg::RATE_MAX) begin
                                        vflag    = 1'b1;
                                        v_status = whp_pkg::ST_RATE;
                                    end else begin
                                        div_req.start   = 1'b1;
                                        div_req.divisor = rate32[whp_pkg::RATE_W-1:0];
                                        phase_next      = PH_DIV;
                                    end
                                end
                            end
                        end
                        PH_SKIP: begin
                            skip_next = skip_next - 32'd1;
                            if (skip_next == '0) begin
                                phase_next = PH_CHDR;
                                count_next = '0;
                            end
                        end
                        default: begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
            if (vflag) begin
                phase_next = PH_IDLE;
            end
        end
    end

    // verdict item
    always_comb begin
        res_valid           = vflag;
        res.status          = v_status;
        res.data_bytes      = v_len;
        res.data_offset     = v_off;
        res.channels        = (align_next != '0) ? fmt_bytes[2][1:0] : 2'd0;
        res.sample_bits     = (align_next != '0) ? fmt_bytes[14][4:0] : 5'd0;
        res.sample_interval = interval_next;
    end

    assign busy = (phase_reg == PH_DIV);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            count_reg    <= '0;
            align_reg    <= '0;
            interval_reg <= '0;
            skip_reg     <= '0;
            offset_reg   <= '0;
        end else begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            align_reg    <= align_next;
            interval_reg <= interval_next;
            skip_reg     <= skip_next;
            offset_reg   <= offset_next;
        end
        tag_reg <= tag_next;
        len_reg <= len_next;
    end

    // fmt body store
    always_ff @(posedge aclk) begin
        if (fmt_we) begin
            fmt_bytes[fmt_idx] <= data_byte;
        end
    end

endmodule
